// ----- hw/rtl/ewer_pkg.sv -----
// shared widths, codes and constants for the moving-average block
package ewer_pkg;

  // field widths
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DELTA_W  = 40;
  localparam int unsigned COUNT_W  = 31;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned WEIGHT_W = 17;

  // fixed point
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned GAP_FRAC_W = 8;

  // rate scaling: one second in Q32.8 microseconds
  localparam int unsigned SCALE_W    = 28;
  localparam logic [SCALE_W-1:0] USEC_SCALE = SCALE_W'(256000000);

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // register port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT = 1'b0;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(4096);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);

endpackage

// ----- hw/rtl/ewer_if.sv -----
// input and result channels of the moving-average block

interface ewer_in_if import ewer_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [CMD_W-1:0]   cmd;
  logic signed [VALUE_W-1:0] sample_value;
  logic        [TIME_W-1:0]  now_us;

  modport source (output valid, cmd, sample_value, now_us, input ready);
  modport sink   (input valid, cmd, sample_value, now_us, output ready);
endinterface

interface ewer_out_if import ewer_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] sample_count;
  logic signed [VALUE_W-1:0] average;
  logic        [DELTA_W-1:0] delta_average_now;
  logic        [TIME_W-1:0]  usecs_since_last;
  logic signed [VALUE_W-1:0] rate_per_second;
  logic                      rate_valid;

  modport source (output valid, sample_count, average, delta_average_now, usecs_since_last,
                  rate_per_second, rate_valid, input ready);
  modport sink   (input valid, sample_count, average, delta_average_now, usecs_since_last,
                  rate_per_second, rate_valid, output ready);
endinterface

// ----- hw/rtl/ema_with_event_rate.sv -----
// moving average of a sample stream with an event-rate estimate
//
// each input transfer carries a command (add sample, clear averages, query) and the
// current microsecond time; every transfer yields exactly one result transfer with the
// sample count, the Q16.16 moving average, the Q32.8 gap average projected to the
// present, the time since the last sample and the average per second. the block works
// on one item at a time: a sample with history first blends the sample and gap averages,
// a query, clear or first sample skips that blend, and the division is skipped when the
// projected gap is zero or the rate quotient would not fit in 32 bits. the work is
// done by two bit-serial shift-add multipliers that walk the 17 weight bits one per
// cycle (the sample and gap averages run side by side, then the projection), and by a
// restoring divider that produces one of the 32 rate quotient bits per cycle. a new
// item is taken while the previous result still waits in the output register. the
// weight register lies at byte address 0 of the register port; writes take effect at
// once and are meant for an idle block
module ema_with_event_rate import ewer_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // channels
  ewer_in_if.sink            in_i,
  ewer_out_if.source         out_o
);

  localparam int unsigned AVG_DIFF_W = VALUE_W + 1;
  localparam int unsigned AVG_ACC_W  = AVG_DIFF_W + WEIGHT_W;
  localparam int unsigned DLT_DIFF_W = DELTA_W + 1;
  localparam int unsigned DLT_ACC_W  = DLT_DIFF_W + WEIGHT_W;
  localparam int unsigned PROD_W     = VALUE_W + SCALE_W;
  localparam int unsigned NUM_W      = VALUE_W + SCALE_W - 1;
  localparam int unsigned BIT_IDX_W  = $clog2(WEIGHT_W);
  localparam int unsigned DIV_IDX_W  = $clog2(VALUE_W);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an input transfer
    S_PREP,   // command decode, first-sample shortcuts, blend operands
    S_MUL1,   // sample and gap blends, one weight bit per cycle
    S_FIN1,   // round and write back the blends
    S_PROJ,   // gap to now, projection operand, rate magnitude
    S_MUL2,   // projection blend
    S_FIN2,   // projection result, rate numerator
    S_CHK,    // zero gap and overflow checks
    S_DIV,    // one quotient bit per cycle
    S_DONE    // saturate, sign and hand over to the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // weight register
  // ---------------------------------------------------------------------------
  logic [WEIGHT_W-1:0] weight_q;
  logic                cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_WEIGHT);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_WEIGHT) ? PDATA_W'(weight_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      weight_q <= pwdata[WEIGHT_W-1:0];
    end
  end

  // weights above one act as one
  logic [WEIGHT_W-1:0] weff;
  assign weff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;

  // gap in Q32.8, saturating
  function automatic logic [DELTA_W-1:0] gap_q8(input logic [TIME_W-1:0] g);
    if (|g[TIME_W-1:DELTA_W-GAP_FRAC_W]) begin
      return '1;
    end
    return {g[DELTA_W-GAP_FRAC_W-1:0], {GAP_FRAC_W{1'b0}}};
  endfunction

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [VALUE_W-1:0]   avg_q, avg_d;
  logic [DELTA_W-1:0]   dlt_q, dlt_d;
  logic [TIME_W-1:0]    last_q, last_d;
  logic                 out_valid_q, out_valid_d;

  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [VALUE_W-1:0]   smp_q, smp_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic [TIME_W-1:0]    gap_q, gap_d;
  logic                 do_avg_q, do_avg_d;
  logic                 do_dlt_q, do_dlt_d;
  logic [AVG_DIFF_W-1:0] avg_diff_q, avg_diff_d;
  logic [AVG_ACC_W-1:0]  acc_avg_q, acc_avg_d;
  logic [DLT_DIFF_W-1:0] dlt_diff_q, dlt_diff_d;
  logic [DLT_ACC_W-1:0]  acc_dlt_q, acc_dlt_d;
  logic [BIT_IDX_W-1:0]  bit_q, bit_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [DELTA_W-1:0]   proj_q, proj_d;
  logic [DELTA_W-1:0]   rem_q, rem_d;
  logic [VALUE_W-1:0]   sh_q, sh_d;       // numerator low bits, then quotient
  logic [DIV_IDX_W-1:0] dcnt_q, dcnt_d;
  logic                 rv_q, rv_d;

  logic [COUNT_W-1:0]   o_count_q, o_count_d;
  logic [VALUE_W-1:0]   o_avg_q, o_avg_d;
  logic [DELTA_W-1:0]   o_proj_q, o_proj_d;
  logic [TIME_W-1:0]    o_gap_q, o_gap_d;
  logic [VALUE_W-1:0]   o_rate_q, o_rate_d;
  logic                 o_rv_q, o_rv_d;

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  logic                 wbit;
  logic [TIME_W-1:0]    gap_now;
  logic [DELTA_W-1:0]   gapq8_now;
  logic [AVG_ACC_W-1:0] avg_rnd;
  logic [DLT_ACC_W-1:0] dlt_rnd;
  logic [PROD_W-1:0]    num_full;
  logic [DELTA_W:0]     div_trial;
  logic                 div_ge;
  logic [VALUE_W-1:0]   limit;
  logic [VALUE_W-1:0]   q_sat;

  assign wbit      = weff[bit_q];
  assign gap_now   = now_q - last_q;
  assign gapq8_now = gap_q8(gap_now);

  // round half up, then the arithmetic shift is a part-select of the sum
  assign avg_rnd = acc_avg_q + AVG_ACC_W'(1 << (FRAC_W - 1));
  assign dlt_rnd = acc_dlt_q + DLT_ACC_W'(1 << (FRAC_W - 1));

  // average magnitude times one second of Q32.8 time
  assign num_full = PROD_W'(mag_q) * PROD_W'(USEC_SCALE);

  // restoring division step
  assign div_trial = {rem_q, sh_q[VALUE_W-1]};
  assign div_ge    = div_trial >= {1'b0, proj_q};

  // largest magnitude for the rate's sign
  assign limit = {neg_q, {(VALUE_W-1){~neg_q}}};
  assign q_sat = (sh_q > limit) ? limit : sh_q;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    avg_d       = avg_q;
    dlt_d       = dlt_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;

    cmd_d      = cmd_q;
    smp_d      = smp_q;
    now_d      = now_q;
    gap_d      = gap_q;
    do_avg_d   = do_avg_q;
    do_dlt_d   = do_dlt_q;
    avg_diff_d = avg_diff_q;
    acc_avg_d  = acc_avg_q;
    dlt_diff_d = dlt_diff_q;
    acc_dlt_d  = acc_dlt_q;
    bit_d      = bit_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    proj_d     = proj_q;
    rem_d      = rem_q;
    sh_d       = sh_q;
    dcnt_d     = dcnt_q;
    rv_d       = rv_q;

    o_count_d = o_count_q;
    o_avg_d   = o_avg_q;
    o_proj_d  = o_proj_q;
    o_gap_d   = o_gap_q;
    o_rate_d  = o_rate_q;
    o_rv_d    = o_rv_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.cmd;
          smp_d   = in_i.sample_value;
          now_d   = in_i.now_us;
          state_d = S_PREP;
        end
      end

      S_PREP: begin
        state_d   = S_PROJ;
        acc_avg_d = '0;
        acc_dlt_d = '0;
        bit_d     = BIT_IDX_W'(WEIGHT_W - 1);
        case (cmd_q)
          CMD_SAMPLE: begin
            last_d  = now_q;
            count_d = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
            if (count_q == '0) begin
              // first sample seeds the average
              avg_d = smp_q;
              dlt_d = '0;
            end else begin
              do_avg_d   = 1'b1;
              avg_diff_d = {smp_q[VALUE_W-1], smp_q} - {avg_q[VALUE_W-1], avg_q};
              // second sample takes the raw gap
              do_dlt_d   = (count_q != COUNT_W'(1));
              dlt_diff_d = {1'b0, gapq8_now} - {1'b0, dlt_q};
              if (count_q == COUNT_W'(1)) begin
                dlt_d = gapq8_now;
              end
              state_d = S_MUL1;
            end
          end
          CMD_CLEAR: begin
            count_d = '0;
            avg_d   = '0;
            dlt_d   = '0;
          end
          default: begin
            // query and unused code leave the state alone
          end
        endcase
      end

      S_MUL1: begin
        acc_avg_d = {acc_avg_q[AVG_ACC_W-2:0], 1'b0}
                    + (wbit ? {{WEIGHT_W{avg_diff_q[AVG_DIFF_W-1]}}, avg_diff_q} : '0);
        acc_dlt_d = {acc_dlt_q[DLT_ACC_W-2:0], 1'b0}
                    + (wbit ? {{WEIGHT_W{dlt_diff_q[DLT_DIFF_W-1]}}, dlt_diff_q} : '0);
        bit_d     = bit_q - BIT_IDX_W'(1);
        if (bit_q == '0) begin
          state_d = S_FIN1;
        end
      end

      S_FIN1: begin
        if (do_avg_q) begin
          avg_d = avg_q + avg_rnd[VALUE_W+FRAC_W-1:FRAC_W];
        end
        if (do_dlt_q) begin
          dlt_d = dlt_q + dlt_rnd[DELTA_W+FRAC_W-1:FRAC_W];
        end
        state_d = S_PROJ;
      end

      S_PROJ: begin
        gap_d      = gap_now;
        dlt_diff_d = {1'b0, gapq8_now} - {1'b0, dlt_q};
        acc_dlt_d  = '0;
        bit_d      = BIT_IDX_W'(WEIGHT_W - 1);
        neg_d      = avg_q[VALUE_W-1];
        // the most negative average maps to a magnitude of 2^31
        mag_d      = avg_q[VALUE_W-1] ? (~avg_q + VALUE_W'(1)) : avg_q;
        do_avg_d   = 1'b0;
        do_dlt_d   = 1'b0;
        state_d    = S_MUL2;
      end

      S_MUL2: begin
        acc_dlt_d = {acc_dlt_q[DLT_ACC_W-2:0], 1'b0}
                    + (wbit ? {{WEIGHT_W{dlt_diff_q[DLT_DIFF_W-1]}}, dlt_diff_q} : '0);
        bit_d     = bit_q - BIT_IDX_W'(1);
        if (bit_q == '0) begin
          state_d = S_FIN2;
        end
      end

      S_FIN2: begin
        proj_d  = dlt_q + dlt_rnd[DELTA_W+FRAC_W-1:FRAC_W];
        rem_d   = DELTA_W'(num_full[NUM_W-1:VALUE_W]);
        sh_d    = num_full[VALUE_W-1:0];
        state_d = S_CHK;
      end

      S_CHK: begin
        dcnt_d = DIV_IDX_W'(VALUE_W - 1);
        if (proj_q == '0) begin
          // zero gap: largest rate for the sign, zero for a zero average
          rv_d    = 1'b0;
          sh_d    = (mag_q == '0) ? '0 : limit;
          state_d = S_DONE;
        end else if (rem_q >= proj_q) begin
          // quotient does not fit the value width
          rv_d    = 1'b0;
          sh_d    = limit;
          state_d = S_DONE;
        end else begin
          rv_d    = 1'b1;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        rem_d  = div_ge ? DELTA_W'(div_trial - {1'b0, proj_q}) : div_trial[DELTA_W-1:0];
        sh_d   = {sh_q[VALUE_W-2:0], div_ge};
        dcnt_d = dcnt_q - DIV_IDX_W'(1);
        if (dcnt_q == '0) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          o_count_d   = count_q;
          o_avg_d     = avg_q;
          o_proj_d    = proj_q;
          o_gap_d     = gap_q;
          o_rate_d    = neg_q ? (~q_sat + VALUE_W'(1)) : q_sat;
          o_rv_d      = rv_q && (sh_q <= limit);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      avg_q       <= '0;
      dlt_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      avg_q       <= avg_d;
      dlt_q       <= dlt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    smp_q      <= smp_d;
    now_q      <= now_d;
    gap_q      <= gap_d;
    do_avg_q   <= do_avg_d;
    do_dlt_q   <= do_dlt_d;
    avg_diff_q <= avg_diff_d;
    acc_avg_q  <= acc_avg_d;
    dlt_diff_q <= dlt_diff_d;
    acc_dlt_q  <= acc_dlt_d;
    bit_q      <= bit_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    proj_q     <= proj_d;
    rem_q      <= rem_d;
    sh_q       <= sh_d;
    dcnt_q     <= dcnt_d;
    rv_q       <= rv_d;
    o_count_q  <= o_count_d;
    o_avg_q    <= o_avg_d;
    o_proj_q   <= o_proj_d;
    o_gap_q    <= o_gap_d;
    o_rate_q   <= o_rate_d;
    o_rv_q     <= o_rv_d;
  end

  // ---------------------------------------------------------------------------
  // channels
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == S_IDLE);

  assign out_o.valid             = out_valid_q;
  assign out_o.sample_count      = o_count_q;
  assign out_o.average           = o_avg_q;
  assign out_o.delta_average_now = o_proj_q;
  assign out_o.usecs_since_last  = o_gap_q;
  assign out_o.rate_per_second   = o_rate_q;
  assign out_o.rate_valid        = o_rv_q;

endmodule
